// ===== rtl/p2rgba_pkg.sv =====
// p2rgba_pkg: shared types, constants and channel functions for the rgba converter
// no dependencies; used by every module under rtl except p2rgba_ram
`timescale 1ns / 1ps

package p2rgba_pkg;

    localparam int P2RGBA_PALETTE_ENTRIES = 256;

    localparam logic [31:0] RED_MASK_RESET   = 32'h00FF_0000;
    localparam logic [31:0] GREEN_MASK_RESET = 32'h0000_FF00;
    localparam logic [31:0] BLUE_MASK_RESET  = 32'h0000_00FF;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // register indexes, byte address 4*index
    localparam logic [1:0] REG_RED_MASK     = 2'd0;
    localparam logic [1:0] REG_GREEN_MASK   = 2'd1;
    localparam logic [1:0] REG_BLUE_MASK    = 2'd2;
    localparam logic [1:0] REG_PALETTE_MODE = 2'd3;

    // input word kinds carried on s_axis_tuser
    localparam logic CMD_CONVERT       = 1'b0;
    localparam logic CMD_PALETTE_WRITE = 1'b1;

    // decoded channel mask: lowest run position and width
    typedef struct packed {
        logic [31:0] mask;
        logic        ok;
        logic [4:0]  pos;
        logic [3:0]  width;
    } chan_dec_t;

    typedef struct packed {
        logic      palette_mode;
        chan_dec_t red;
        chan_dec_t green;
        chan_dec_t blue;
    } cfg_t;

    // conversion word held between input register and result register
    typedef struct packed {
        logic [31:0] pixel;
        logic        index_oor;
    } pix_item_t;

    function automatic chan_dec_t lowest_run_decode(input logic [31:0] mask);
        chan_dec_t  d;
        logic [31:0] sh;
        logic       run;
        logic [3:0] n;
        d.mask = mask;
        d.pos  = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (mask[i])
            begin
                d.pos = 5'(i);
            end
        end
        sh  = mask >> d.pos;
        n   = '0;
        run = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (run && sh[i])
            begin
                n = n + 4'd1;
            end
            else
            begin
                run = 1'b0;
            end
        end
        d.width = n;
        // supported widths are 2 to 8
        d.ok = (mask != '0) && sh[1] && !(&sh[8:0]);
        return d;
    endfunction

    // bit replication on the whole 8-bit field
    function automatic logic [7:0] widen(input logic [7:0] v, input logic [3:0] w);
        logic [15:0] t;
        logic [7:0]  r;
        t = {8'h00, v};
        unique case (w)
            4'd8:    r = v;
            4'd7:    r = 8'((t << 1) | (t >> 6));
            4'd6:    r = 8'((t << 2) | (t >> 4));
            4'd5:    r = 8'((t << 3) | (t >> 2));
            4'd4:    r = 8'((t << 4) | t);
            4'd3:    r = 8'((t << 5) | (t << 2) | (t >> 1));
            default: r = 8'((t << 6) | (t << 4) | (t << 2) | t);
        endcase
        return r;
    endfunction

    function automatic logic [7:0] chan_extract(input logic [31:0] pixel,
                                                input chan_dec_t d);
        logic [31:0] field;
        field = (pixel & d.mask) >> d.pos;
        return widen(field[7:0], d.width);
    endfunction

endpackage

// ===== rtl/p2rgba_ram.sv =====
// p2rgba_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module p2rgba_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/p2rgba_cfg.sv =====
// p2rgba_cfg: apb register file for channel masks and palette mode
// depends on p2rgba_pkg; masks are decoded as they are written
`timescale 1ns / 1ps

module p2rgba_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output p2rgba_pkg::cfg_t   cfg
);

    p2rgba_pkg::cfg_t      cfg_reg;
    p2rgba_pkg::cfg_t      cfg_next;
    p2rgba_pkg::chan_dec_t wdec;
    logic                  wr_en;
    logic [1:0]            reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign wdec    = p2rgba_pkg::lowest_run_decode(pwdata);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                p2rgba_pkg::REG_RED_MASK:     cfg_next.red          = wdec;
                p2rgba_pkg::REG_GREEN_MASK:   cfg_next.green        = wdec;
                p2rgba_pkg::REG_BLUE_MASK:    cfg_next.blue         = wdec;
                p2rgba_pkg::REG_PALETTE_MODE: cfg_next.palette_mode = pwdata[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.palette_mode <= 1'b0;
            cfg_reg.red   <= p2rgba_pkg::lowest_run_decode(p2rgba_pkg::RED_MASK_RESET);
            cfg_reg.green <= p2rgba_pkg::lowest_run_decode(p2rgba_pkg::GREEN_MASK_RESET);
            cfg_reg.blue  <= p2rgba_pkg::lowest_run_decode(p2rgba_pkg::BLUE_MASK_RESET);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            p2rgba_pkg::REG_RED_MASK:     prdata = cfg_reg.red.mask;
            p2rgba_pkg::REG_GREEN_MASK:   prdata = cfg_reg.green.mask;
            p2rgba_pkg::REG_BLUE_MASK:    prdata = cfg_reg.blue.mask;
            p2rgba_pkg::REG_PALETTE_MODE: prdata = {31'b0, cfg_reg.palette_mode};
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/p2rgba_conv.sv =====
// p2rgba_conv: channel extraction or palette pick, and the result register
// depends on p2rgba_pkg; palette data arrives from the registered ram read
`timescale 1ns / 1ps

module p2rgba_conv (
    input  logic                    clk,
    input  logic                    rst_n,
    input  p2rgba_pkg::cfg_t        cfg,
    input  logic                    item_valid,
    input  p2rgba_pkg::pix_item_t   item,
    input  logic [23:0]             pal_data,
    output logic                    item_ready,
    output logic                    out_valid,
    output logic [31:0]             out_word,
    output logic                    out_error,
    input  logic                    out_ready
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] word_reg;
    logic        error_reg;
    logic [31:0] word_next;
    logic        error_next;
    logic        load;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;

    assign item_ready = !out_valid_reg || out_ready;
    assign load       = item_valid && item_ready;

    assign r = p2rgba_pkg::chan_extract(item.pixel, cfg.red);
    assign g = p2rgba_pkg::chan_extract(item.pixel, cfg.green);
    assign b = p2rgba_pkg::chan_extract(item.pixel, cfg.blue);

    always_comb
    begin
        if (cfg.palette_mode)
        begin
            error_next = item.index_oor;
            word_next  = {p2rgba_pkg::ALPHA_OPAQUE, pal_data};
        end
        else
        begin
            error_next = !(cfg.red.ok && cfg.green.ok && cfg.blue.ok);
            word_next  = {p2rgba_pkg::ALPHA_OPAQUE, b, g, r};
        end
        if (error_next)
        begin
            word_next = '0;
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg  <= word_next;
            error_reg <= error_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = word_reg;
    assign out_error = error_reg;

endmodule

// ===== rtl/pixel_to_rgba8888_converter.sv =====
// pixel_to_rgba8888_converter: an accepted word passes the input register, then the
// result register; throughput one word per cycle while m_axis_tready is high
// input register and result register pipeline the palette ram read and the channel
// logic, stalls propagate back through both; palette writes give no result
// reset clears the pipeline valid bits and loads the register reset values;
// palette contents stay undefined until written
`timescale 1ns / 1ps

module pixel_to_rgba8888_converter #(
    parameter int PALETTE_ENTRIES = p2rgba_pkg::P2RGBA_PALETTE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pixel_value[31:0], entry_index[39:32], entry_red[47:40],
    // entry_green[55:48], entry_blue[63:56]
    input  logic [63:0] s_axis_tdata,
    // cmd[0]
    input  logic [0:0]  s_axis_tuser,
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // rgba_word[31:0]
    output logic [31:0] m_axis_tdata,
    // format_error[0]
    output logic [0:0]  m_axis_tuser,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    p2rgba_pkg::cfg_t      cfg;
    p2rgba_pkg::pix_item_t s1_item_reg;
    p2rgba_pkg::pix_item_t s1_item_next;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_ready;
    logic                  accept;
    logic                  is_write;
    logic [31:0]           pixel_value;
    logic [7:0]            entry_index;
    logic                  pal_wr_en;
    logic                  pal_rd_en;
    logic [23:0]           pal_wr_data;
    logic [23:0]           pal_rd_data;

    assign pixel_value = s_axis_tdata[31:0];
    assign entry_index = s_axis_tdata[39:32];
    assign pal_wr_data = s_axis_tdata[63:40];
    assign is_write    = (s_axis_tuser[0] == p2rgba_pkg::CMD_PALETTE_WRITE);

    assign s_axis_tready = !s1_valid_reg || s1_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // out-of-range entry writes are dropped
    assign pal_wr_en = accept && is_write && ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));
    assign pal_rd_en = accept && !is_write;

    p2rgba_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    p2rgba_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_wr_en),
        .wr_addr (entry_index[AW-1:0]),
        .wr_data (pal_wr_data),
        .rd_en   (pal_rd_en),
        .rd_addr (pixel_value[AW-1:0]),
        .rd_data (pal_rd_data)
    );

    always_comb
    begin
        s1_item_next.pixel     = pixel_value;
        s1_item_next.index_oor = (pixel_value >= 32'(PALETTE_ENTRIES));
        if (accept)
        begin
            s1_valid_next = !is_write;
        end
        else if (s1_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_rd_en)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    p2rgba_conv u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (s1_valid_reg),
        .item       (s1_item_reg),
        .pal_data   (pal_rd_data),
        .item_ready (s1_ready),
        .out_valid  (m_axis_tvalid),
        .out_word   (m_axis_tdata),
        .out_error  (m_axis_tuser[0]),
        .out_ready  (m_axis_tready)
    );

    a_error_zero_word : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 32'h0))
        else $error("error word with nonzero pixel");

    a_alpha_opaque : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[31:24] == 8'hFF))
        else $error("good word without opaque alpha");

    a_write_no_result : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_write) |=> !s1_valid_reg)
        else $error("palette write entered the conversion stage");

    a_stage_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_ready) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("stalled conversion word lost");

endmodule
